[design/lncc_pkg.sv]
// Package for the windowed NCC dissimilarity unit.
// Holds the beat types, configuration register indexes and fixed-point constants.
// No dependencies.
package lncc_pkg;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_PLANE_COUNT  = 3'd2,
    CFG_HALF_X       = 3'd3,
    CFG_HALF_Y       = 3'd4,
    CFG_USE_MASK     = 3'd5
  } cfg_idx_e;

  // Fixed-point constants of the dissimilarity scaling.
  localparam logic [16:0] Q_ONE      = 17'd65536;
  localparam logic [7:0]  DISS_SCALE = 8'd255;
  localparam logic [15:0] Q_ROUND    = 16'd32768;

  // Input beat: one pixel pair and its mask bit.
  typedef struct packed {
    logic [7:0] cur_pixel;
    logic [7:0] prev_pixel;
    logic       mask_bit;
  } in_beat_t;

  // Output beat: one window centre and its dissimilarity.
  typedef struct packed {
    logic [9:0]  col;
    logic [15:0] row;
    logic [15:0] plane;
    logic [7:0]  dissimilarity;
  } out_beat_t;

endpackage

[design/lncc_root_div.sv]
// Square root and division unit of the NCC dissimilarity block.
// Computes floor(sqrt(s1*s2)), then the Q16 correlation and its 0..255 scaling.
// Depends on lncc_pkg.
module lncc_root_div #(
  parameter int SW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [SW-1:0] s1_i,
  input  logic [SW-1:0] s2_i,
  input  logic [SW-1:0] sp_i,
  output logic          done_o,
  output logic [7:0]    diss_o
);
  import lncc_pkg::*;

  localparam int NW  = 2 * SW;
  localparam int DW  = SW + 16;
  localparam int CNW = $clog2(DW + 1);

  typedef enum logic [1:0] {M_IDLE, M_SQRT, M_DIV, M_SCALE} mstate_e;

  mstate_e          state_q;
  logic [NW-1:0]    n_q, res_q, bit_q;
  logic [SW-1:0]    rem_q;
  logic [DW-1:0]    num_q;
  logic [CNW-1:0]   cnt_q;
  logic             done_q;
  logic [7:0]       diss_q;

  logic [NW-1:0]    trial;
  logic             sq_ge;
  logic [SW-1:0]    root;
  logic [SW:0]      dtrial;
  logic             dv_ge;
  logic             q_big;
  logic [16:0]      q_cap;
  logic [24:0]      scaled;

  // One square-root step: try to set the next result bit.
  assign trial = res_q + bit_q;
  assign sq_ge = (n_q >= trial);
  assign root  = res_q[SW-1:0];

  // One restoring division step.
  assign dtrial = {rem_q, num_q[DW-1]};
  assign dv_ge  = (dtrial >= {1'b0, root});

  // Cap the quotient at 1.0 and scale to 0..255 with rounding.
  assign q_big  = (|num_q[DW-1:17]) || (num_q[16:0] > Q_ONE);
  assign q_cap  = q_big ? Q_ONE : num_q[16:0];
  assign scaled = 25'(DISS_SCALE) * 25'(Q_ONE - q_cap) + 25'(Q_ROUND);

  // Sequencer of the root and divide iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      n_q     <= '0;
      res_q   <= '0;
      bit_q   <= '0;
      rem_q   <= '0;
      num_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      diss_q  <= '0;
    end else begin
      done_q <= (state_q == M_SCALE);
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            n_q     <= s1_i * s2_i;
            res_q   <= '0;
            bit_q   <= NW'(1) << (NW - 2);
            state_q <= M_SQRT;
          end
        end
        M_SQRT: begin
          if (sq_ge) begin
            n_q   <= n_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            rem_q   <= '0;
            num_q   <= {sp_i, 16'd0};
            cnt_q   <= CNW'(DW);
            state_q <= M_DIV;
          end
        end
        M_DIV: begin
          rem_q <= dv_ge ? dtrial[SW-1:0] - root : dtrial[SW-1:0];
          num_q <= {num_q[DW-2:0], dv_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNW'(1)) begin
            state_q <= M_SCALE;
          end
        end
        M_SCALE: begin
          diss_q  <= scaled[23:16];
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign diss_o = diss_q;

endmodule

[design/local_ncc_dissimilarity_slices_unit.sv]
// Windowed normalized cross-correlation dissimilarity between consecutive planes.
// An input beat that produces no result is taken without a stall. A beat that completes
// a window stalls the input while the window is read from the line memory one pixel
// per cycle and the sums settle, then while the bit-serial square root and divider
// (SW = 22 at MAX_HALF = 3) run, skipped when an energy is zero, and during any wait
// on a stalled output register; a masked centre ends after the window read. No new
// beat is taken until that result is through. The single read port of the line
// memory and the shared root/divide unit set this.
// Depends on lncc_pkg and lncc_root_div.
module local_ncc_dissimilarity_slices_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF  = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lncc_pkg::in_beat_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lncc_pkg::out_beat_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [lncc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lncc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lncc_pkg::*;

  localparam int ROW_SLOTS = 2 * MAX_HALF + 1;
  localparam int DEPTH     = ROW_SLOTS * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int SLW       = $clog2(ROW_SLOTS);
  localparam int HW        = $clog2(MAX_HALF + 1);
  localparam int SW        = $clog2(ROW_SLOTS * ROW_SLOTS * 65025 + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_EVAL, S_MATH, S_OUT} state_e;

  // Configuration registers.
  logic [10:0] image_width_q;
  logic [15:0] image_height_q, plane_count_q;
  logic [1:0]  half_x_q, half_y_q;
  logic        use_mask_q;

  // Raster position and row slot of the next pixel.
  logic [CW-1:0]  col_q;
  logic [15:0]    row_q, plane_q;
  logic [SLW-1:0] slot_q;

  state_e         state_q;
  logic [HW:0]    kc_q, kr_q;
  logic [SLW-1:0] sc_slot_q;
  logic [CW-1:0]  sc_col0_q;
  logic           rd_vld_q, rd_ctr_q;
  out_beat_t      res_q, out_data_q;
  logic           out_valid_q;

  in_beat_t       line_mem [DEPTH];
  in_beat_t       rd_data_q;
  logic [SW-1:0]  s1_q, s2_q, sp_q;
  logic           mask_c_q;

  logic [WW-1:0]  w;
  logic [15:0]    h, np;
  logic [2:0]     hx_w, hy_w;
  logic [HW-1:0]  hx, hy;
  logic [HW:0]    hx2, hy2;
  logic [CW-1:0]  cx;
  logic [15:0]    cy, cz;
  logic [SLW-1:0] slot_eff, slot_top, slot_inc;
  logic [SLW:0]   slot_a, slot_b;
  logic           in_accept, emit, col_wrap, row_wrap;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [CW-1:0]  rd_col;
  logic [15:0]    pa, pb, pc;
  logic           skip, zero_e, math_start, math_done, out_load;
  logic [7:0]     math_diss;

  // Saturate the geometry registers.
  always_comb begin
    if (image_width_q == '0) begin
      w = WW'(1);
    end else if ({5'd0, image_width_q} > 16'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width_q);
    end
    h    = (image_height_q == '0) ? 16'd1 : image_height_q;
    np   = (plane_count_q == '0) ? 16'd1 : plane_count_q;
    hx_w = (half_x_q == '0) ? 3'd1 :
           (({1'b0, half_x_q} > 3'(MAX_HALF)) ? 3'(MAX_HALF) : {1'b0, half_x_q});
    hy_w = (half_y_q == '0) ? 3'd1 :
           (({1'b0, half_y_q} > 3'(MAX_HALF)) ? 3'(MAX_HALF) : {1'b0, half_y_q});
  end
  assign hx  = hx_w[HW-1:0];
  assign hy  = hy_w[HW-1:0];
  assign hx2 = {hx, 1'b0};
  assign hy2 = {hy, 1'b0};

  // Current position, with counters beyond a shrunk limit taken as zero.
  assign cx       = (WW'(col_q) >= w) ? '0 : col_q;
  assign cy       = (row_q >= h) ? '0 : row_q;
  assign slot_eff = (row_q >= h) ? '0 : slot_q;
  assign cz       = (plane_q >= np) ? '0 : plane_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign emit      = (cz != '0) && (cx >= CW'(hx2)) && (cy >= 16'(hy2));
  assign col_wrap  = (WW'(cx) + WW'(1)) >= w;
  assign row_wrap  = (17'(cy) + 17'd1) >= 17'(h);

  // Row slot of the top window row.
  assign slot_a   = {1'b0, slot_eff};
  assign slot_b   = (SLW+1)'(hy2);
  assign slot_top = (slot_a >= slot_b) ? SLW'(slot_a - slot_b)
                                       : SLW'(slot_a + (SLW+1)'(ROW_SLOTS) - slot_b);
  assign slot_inc = (sc_slot_q == SLW'(ROW_SLOTS - 1)) ? '0 : sc_slot_q + 1'b1;

  // Line memory addressing.
  assign wr_addr = AW'(slot_eff) * AW'(MAX_WIDTH) + AW'(cx);
  assign rd_col  = sc_col0_q + CW'(kc_q);
  assign rd_addr = AW'(sc_slot_q) * AW'(MAX_WIDTH) + AW'(rd_col);

  // Line memory: one write port for the stream, one read port for the window.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      line_mem[wr_addr] <= in_data_i;
    end
    if (state_q == S_SCAN) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  // Window energy accumulation.
  assign pa = rd_data_q.cur_pixel * rd_data_q.cur_pixel;
  assign pb = rd_data_q.prev_pixel * rd_data_q.prev_pixel;
  assign pc = rd_data_q.cur_pixel * rd_data_q.prev_pixel;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q     <= '0;
      s2_q     <= '0;
      sp_q     <= '0;
      mask_c_q <= 1'b0;
    end else if (rd_vld_q) begin
      s1_q <= s1_q + SW'(pa);
      s2_q <= s2_q + SW'(pb);
      sp_q <= sp_q + SW'(pc);
      if (rd_ctr_q) begin
        mask_c_q <= rd_data_q.mask_bit;
      end
    end
  end

  // Result decision once the window is summed.
  assign skip       = use_mask_q && !mask_c_q;
  assign zero_e     = (s1_q == '0) || (s2_q == '0);
  assign math_start = (state_q == S_EVAL) && !skip && !zero_e;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  lncc_root_div #(
    .SW (SW)
  ) u_root_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (math_start),
    .s1_i    (s1_q),
    .s2_i    (s2_q),
    .sp_i    (sp_q),
    .done_o  (math_done),
    .diss_o  (math_diss)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 11'd256;
      image_height_q <= 16'd256;
      plane_count_q  <= 16'd1;
      half_x_q       <= 2'd1;
      half_y_q       <= 2'd1;
      use_mask_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        CFG_PLANE_COUNT:  plane_count_q  <= cfg_data_i;
        CFG_HALF_X:       half_x_q       <= cfg_data_i[1:0];
        CFG_HALF_Y:       half_y_q       <= cfg_data_i[1:0];
        CFG_USE_MASK:     use_mask_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Raster counters, window scan and result sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      plane_q     <= '0;
      slot_q      <= '0;
      kc_q        <= '0;
      kr_q        <= '0;
      sc_slot_q   <= '0;
      sc_col0_q   <= '0;
      rd_vld_q    <= 1'b0;
      rd_ctr_q    <= 1'b0;
      res_q       <= '0;
      out_data_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_SCAN);
      rd_ctr_q <= (state_q == S_SCAN) && (kc_q == (HW+1)'(hx)) &&
                  (kr_q == (HW+1)'(hy));
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (col_wrap) begin
              col_q <= '0;
              if (row_wrap) begin
                row_q   <= '0;
                slot_q  <= '0;
                plane_q <= ((17'(cz) + 17'd1) >= 17'(np)) ? '0 : cz + 16'd1;
              end else begin
                row_q   <= cy + 16'd1;
                slot_q  <= (slot_eff == SLW'(ROW_SLOTS - 1)) ? '0 : slot_eff + 1'b1;
                plane_q <= cz;
              end
            end else begin
              col_q   <= cx + 1'b1;
              row_q   <= cy;
              slot_q  <= slot_eff;
              plane_q <= cz;
            end
            if (emit) begin
              kc_q      <= '0;
              kr_q      <= '0;
              sc_slot_q <= slot_top;
              sc_col0_q <= cx - CW'(hx2);
              res_q.col   <= 10'(cx - CW'(hx));
              res_q.row   <= cy - 16'(hy);
              res_q.plane <= cz;
              state_q     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (kc_q == hx2) begin
            kc_q      <= '0;
            kr_q      <= kr_q + 1'b1;
            sc_slot_q <= slot_inc;
            if (kr_q == hy2) begin
              state_q <= S_DRAIN;
            end
          end else begin
            kc_q <= kc_q + 1'b1;
          end
        end
        S_DRAIN: state_q <= S_EVAL;
        S_EVAL: begin
          if (skip) begin
            state_q <= S_IDLE;
          end else if (zero_e) begin
            res_q.dissimilarity <= '0;
            state_q             <= S_OUT;
          end else begin
            state_q <= S_MATH;
          end
        end
        S_MATH: begin
          if (math_done) begin
            res_q.dissimilarity <= math_diss;
            state_q             <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data_q <= res_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The root/divide unit only runs on a window with nonzero energies.
  a_math_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MATH |-> (s1_q != '0) && (s2_q != '0))
    else $error("root/divide running on zero energy");

  // Window reads only come back during the scan or the drain cycle.
  a_rd_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN) || (state_q == S_DRAIN))
    else $error("line memory read outside the window scan");

  // The column counter stays inside one memory row.
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < WW'(MAX_WIDTH))
    else $error("column counter beyond the line memory row");

  // A result beat is loaded only into a free or draining output register.
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == S_IDLE))
    else $error("result beat not presented after load");

endmodule

[verif/local_ncc_dissimilarity_slices_unit_tb.sv]
// Testbench for the windowed NCC dissimilarity unit.
// Whole volumes of random pixel pairs go in, and every result is checked against a predictor.
// Depends on lncc_pkg and local_ncc_dissimilarity_slices_unit.
`timescale 1ns / 100ps

module local_ncc_dissimilarity_slices_unit_tb;
  import lncc_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 3;
  localparam int SLOTS = 2 * MAXH + 1;
  // Slowest result: window read plus root and divide, rounded up.
  localparam int DRAIN_CYCLES = 200;

  // Kinds of pixel pairs that the stimulus mixes.
  typedef enum int {FLV_RANDOM, FLV_EQUAL, FLV_NEAR, FLV_DARK} flavor_e;

  // Predicts the dissimilarity of each window centre and holds the results still owed.
  class diss_scoreboard;
    byte unsigned cur_mem[SLOTS*MAXW];
    byte unsigned prev_mem[SLOTS*MAXW];
    bit           mask_mem[SLOTS*MAXW];
    int unsigned  col_n, row_n, plane_n;
    int unsigned  width_r, height_r, planes_r, hx_r, hy_r, mask_r;
    out_beat_t    owed[$];
    int           errors;

    function new();
      col_n = 0; row_n = 0; plane_n = 0;
      width_r = 256; height_r = 256; planes_r = 1;
      hx_r = 1; hy_r = 1; mask_r = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, int unsigned v);
      case (idx)
        CFG_IMAGE_WIDTH:  width_r  = v & 'h7FF;
        CFG_IMAGE_HEIGHT: height_r = v & 'hFFFF;
        CFG_PLANE_COUNT:  planes_r = v & 'hFFFF;
        CFG_HALF_X:       hx_r     = v & 3;
        CFG_HALF_Y:       hy_r     = v & 3;
        CFG_USE_MASK:     mask_r   = v & 1;
        default: ;
      endcase
    endfunction

    // Effective values after the block saturates out-of-range registers.
    function int unsigned eff_w();
      return (width_r < 1) ? 1 : (width_r > MAXW) ? MAXW : width_r;
    endfunction
    function int unsigned eff_h();
      return (height_r < 1) ? 1 : height_r;
    endfunction
    function int unsigned eff_np();
      return (planes_r < 1) ? 1 : planes_r;
    endfunction
    function int unsigned eff_hx();
      return (hx_r < 1) ? 1 : (hx_r > MAXH) ? MAXH : hx_r;
    endfunction
    function int unsigned eff_hy();
      return (hy_r < 1) ? 1 : (hy_r > MAXH) ? MAXH : hy_r;
    endfunction

    // Bitwise integer square root, rounded down.
    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Stores one accepted pixel and queues the result it completes, if any.
    function void note_input(in_beat_t b);
      int unsigned w, h, np, hx, hy, cx, cy, cz, ccol, crow, base, d;
      longint unsigned s1, s2, sp, a, p, root, q;
      w = eff_w(); h = eff_h(); np = eff_np(); hx = eff_hx(); hy = eff_hy();
      cx = (col_n >= w) ? 0 : col_n;
      cy = (row_n >= h) ? 0 : row_n;
      cz = (plane_n >= np) ? 0 : plane_n;
      cur_mem[(cy % SLOTS) * MAXW + cx]  = b.cur_pixel;
      prev_mem[(cy % SLOTS) * MAXW + cx] = b.prev_pixel;
      mask_mem[(cy % SLOTS) * MAXW + cx] = b.mask_bit;
      if (cz >= 1 && cx >= 2 * hx && cy >= 2 * hy) begin
        ccol = cx - hx;
        crow = cy - hy;
        if (!(mask_r != 0 && mask_mem[(crow % SLOTS) * MAXW + ccol] == 0)) begin
          s1 = 0; s2 = 0; sp = 0; d = 0;
          for (int unsigned r = cy - 2 * hy; r <= cy; r++) begin
            base = (r % SLOTS) * MAXW;
            for (int unsigned c = cx - 2 * hx; c <= cx; c++) begin
              a = cur_mem[base + c];
              p = prev_mem[base + c];
              s1 += a * a;
              s2 += p * p;
              sp += a * p;
            end
          end
          if (s1 != 0 && s2 != 0) begin
            root = int_sqrt(s1 * s2);
            q = (sp << 16) / root;
            if (q > 65536) q = 65536;
            d = 32'((255 * (65536 - q) + 32768) >> 16);
          end
          owed.push_back('{col: ccol[9:0], row: crow[15:0], plane: cz[15:0],
                           dissimilarity: d[7:0]});
        end
      end
      cx++;
      if (cx >= w) begin
        cx = 0;
        cy++;
        if (cy >= h) begin
          cy = 0;
          cz++;
          if (cz >= np) cz = 0;
        end
      end
      col_n = cx; row_n = cy; plane_n = cz;
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check(out_beat_t o);
      out_beat_t e;
      if (owed.size() == 0) begin
        $error("Unexpected result beat col=%0d row=%0d plane=%0d diss=%0d",
               o.col, o.row, o.plane, o.dissimilarity);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (o.col !== e.col) begin
        $error("col: expected %0d, got %0d", e.col, o.col);
        errors++;
      end
      if (o.row !== e.row) begin
        $error("row: expected %0d, got %0d", e.row, o.row);
        errors++;
      end
      if (o.plane !== e.plane) begin
        $error("plane: expected %0d, got %0d", e.plane, o.plane);
        errors++;
      end
      if (o.dissimilarity !== e.dissimilarity) begin
        $error("dissimilarity: expected %0d, got %0d", e.dissimilarity, o.dissimilarity);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_beat_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_beat_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  diss_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  local_ncc_dissimilarity_slices_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // 100 MHz clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard limit in case the block hangs.
  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check accepted beats, then pick the next stall.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_data_o);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one beat, with random idle cycles first, and waits for it to be taken.
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
  endtask

  // Waits until every owed result is in and the block has gone quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v[CFG_DATA_W-1:0];
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned np,
                              int unsigned hx, int unsigned hy, int unsigned msk);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_PLANE_COUNT, np);
    write_reg(CFG_HALF_X, hx);
    write_reg(CFG_HALF_Y, hy);
    write_reg(CFG_USE_MASK, msk);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pixel pair of a given flavor: independent, equal, nearly equal, or dark.
  function automatic in_beat_t make_pixel(flavor_e flavor);
    in_beat_t b;
    b.cur_pixel  = 8'($urandom_range(255));
    b.mask_bit   = ($urandom_range(99) < 80);
    case (flavor)
      FLV_EQUAL: b.prev_pixel = b.cur_pixel;
      FLV_NEAR:  b.prev_pixel = b.cur_pixel ^ 8'($urandom_range(7));
      FLV_DARK: begin
        b.cur_pixel  = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'd0;
        b.prev_pixel = 8'($urandom_range(255));
      end
      default: b.prev_pixel = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Sends the given number of whole planes in raster order.
  task automatic send_planes(int unsigned n);
    int unsigned total;
    flavor_e flavor;
    total = n * sb.eff_w() * sb.eff_h();
    flavor = flavor_e'($urandom_range(3));
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(63) == 0) flavor = flavor_e'($urandom_range(3));
      send_beat(make_pixel(flavor));
    end
  endtask

  task automatic random_phase();
    set_geometry($urandom_range(12, 3), $urandom_range(8, 3), $urandom_range(3, 2),
                 $urandom_range(3), $urandom_range(3), $urandom_range(1));
    send_planes(sb.eff_np());
    drain();
  endtask

  initial begin
    in_beat_t b;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_IMAGE_WIDTH;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 4x3 planes, two centres; first window holds a black column, second a white one.
    send_idle_pct = 29;
    recv_idle_pct = 61;
    set_geometry(4, 3, 2, 1, 1, 0);
    for (int i = 0; i < 12; i++) begin
      b = '{cur_pixel: 8'(i * 21), prev_pixel: 8'(255 - i * 21), mask_bit: 1'b1};
      send_beat(b);
    end
    for (int i = 0; i < 12; i++) begin
      b.cur_pixel  = (i % 4 == 0) ? 8'd0 : (i % 4 == 3) ? 8'd255 : 8'(i * 17);
      b.prev_pixel = (i % 4 == 0) ? 8'd0 : 8'd255;
      b.mask_bit   = i[0];
      send_beat(b);
    end
    drain();

    // Receiver holds off for a long stretch while pixels keep coming.
    set_geometry(10, 5, 2, 1, 1, 0);
    hold_left = 600;
    send_planes(2);
    drain();

    for (int i = 0; i < 4; i++) random_phase();
    send_idle_pct = 61;
    recv_idle_pct = 29;
    for (int i = 0; i < 4; i++) random_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 2; i++) random_phase();

    // Wider rows with the mask in use, then the largest window.
    set_geometry(24, 3, 2, 1, 1, 1);
    send_planes(2);
    drain();
    set_geometry(9, 8, 2, 3, 3, 0);
    send_planes(2);
    drain();

    // Longest volume: the plane counter never wraps here.
    set_geometry(5, 3, 65535, 2, 1, 1);
    send_planes(4);
    drain();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
